FILE: src/cgd_pkg.sv
// package for the codebook group dequantizer
// shared types, register indexes, state codes and fixed limits; no dependencies
`default_nettype none

package cgd_pkg;

    // fixed clamps applied to the group and row length registers
    localparam int MAX_GROUP = 4096;
    localparam int MAX_ROW   = 65535;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_CODE_WIDTH   = 2'd0,
        CFG_GROUP_LENGTH = 2'd1,
        CFG_ROW_LENGTH   = 2'd2,
        CFG_ROW_COUNT    = 2'd3
    } t_cfg_idx;

    localparam int CFG_DATA_W = 16;

    // register reset values
    localparam logic [3:0]  RST_CODE_WIDTH   = 4'd4;
    localparam logic [12:0] RST_GROUP_LENGTH = 13'd64;
    localparam logic [15:0] RST_ROW_LENGTH   = 16'd4096;
    localparam logic [15:0] RST_ROW_COUNT    = 16'd4096;

    // input operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_BYTE = 1'b1;

    // input item
    typedef struct packed {
        logic        op;
        logic [7:0]  entry_index;
        logic [31:0] entry_value;
        logic [7:0]  data_byte;
    } t_in_item;

    // result item
    typedef struct packed {
        logic [31:0] weight_bits;
        logic [15:0] column;
        logic        row_end;
        logic        matrix_end;
        logic        item_end;
        logic        scale_bad;
    } t_out_item;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UNPACK,
        ST_READ,
        ST_MUL,
        ST_OUT
    } t_state;

endpackage

`default_nettype wire

FILE: src/cgd_if.sv
// valid/ready channel interfaces for input items and result items
// payload types come from cgd_pkg
`default_nettype none

interface cgd_in_if;
    logic              valid;
    logic              ready;
    cgd_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cgd_out_if;
    logic               valid;
    logic               ready;
    cgd_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: src/cgd_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module cgd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: src/cgd_fmul.sv
// four stage ieee single multiplier, round to nearest even, gradual underflow
// used one product at a time by the dequantizer sequencer; no dependencies
`default_nettype none

module cgd_fmul (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_start,
    input  wire  [31:0] i_a,
    input  wire  [31:0] i_b,
    output logic        o_done,
    output logic [31:0] o_result
);

    typedef struct packed {
        logic signed [9:0] x;
        logic [23:0]       f;
    } t_norm;

    // unpack one operand, normalizing a subnormal significand
    function automatic t_norm norm_op(input logic [7:0] ex, input logic [22:0] fr);
        t_norm       res;
        logic [23:0] v;
        logic [4:0]  lz;
        v  = {1'b0, fr};
        lz = 5'd0;
        for (int i = 0; i < 24; i++) begin
            if (v[i]) begin
                lz = 5'(23 - i);
            end
        end
        if (ex == 8'd0) begin
            res.x = 10'sd1 - $signed({5'd0, lz});
            res.f = v << lz;
        end else begin
            res.x = $signed({2'b00, ex});
            res.f = {1'b1, fr};
        end
        return res;
    endfunction

    logic [3:0] r_v;

    // stage 1: specials and unpack
    logic              r1_sg, r1_spec;
    logic [31:0]       r1_val;
    logic signed [9:0] r1_xa, r1_xb;
    logic [23:0]       r1_fa, r1_fb;

    // stage 2: product
    logic               r2_sg, r2_spec;
    logic [31:0]        r2_val;
    logic [47:0]        r2_p;
    logic signed [11:0] r2_e;

    // stage 3: alignment and round decision
    logic               r3_sg, r3_spec, r3_zero, r3_inc;
    logic [31:0]        r3_val;
    logic [23:0]        r3_q;
    logic signed [11:0] r3_e;

    logic        w_sg, w_za, w_zb, w_spec;
    logic [31:0] w_val;
    t_norm       w_na, w_nb;

    always_comb begin
        w_sg   = i_a[31] ^ i_b[31];
        w_za   = (i_a[30:23] == 8'd0) && (i_a[22:0] == 23'd0);
        w_zb   = (i_b[30:23] == 8'd0) && (i_b[22:0] == 23'd0);
        w_spec = 1'b1;
        w_val  = 32'd0;
        if (i_a[30:23] == 8'hFF && i_a[22:0] != 23'd0) begin
            w_val = i_a | 32'h0040_0000;
        end else if (i_b[30:23] == 8'hFF && i_b[22:0] != 23'd0) begin
            w_val = i_b | 32'h0040_0000;
        end else if (i_a[30:23] == 8'hFF || i_b[30:23] == 8'hFF) begin
            w_val = (w_za || w_zb) ? 32'h7FC0_0000 : {w_sg, 31'h7F80_0000};
        end else if (w_za || w_zb) begin
            w_val = {w_sg, 31'd0};
        end else begin
            w_spec = 1'b0;
        end
        w_na = norm_op(i_a[30:23], i_a[22:0]);
        w_nb = norm_op(i_b[30:23], i_b[22:0]);
    end

    // stage 3 alignment logic
    logic               w_big;
    logic signed [11:0] w_e3, w_sh, w_s;
    logic [5:0]         w_s6;
    logic [47:0]        w_q, w_g, w_mask;
    logic               w_guard, w_sticky;

    always_comb begin
        w_big    = r2_p[47];
        w_sh     = w_big ? 12'sd24 : 12'sd23;
        w_e3     = r2_e + (w_big ? 12'sd1 : 12'sd0);
        w_s      = (w_e3 <= 12'sd0) ? (12'sd1 + w_sh - w_e3) : w_sh;
        w_s6     = w_s[5:0];
        w_q      = r2_p >> w_s6;
        w_g      = r2_p >> (w_s6 - 6'd1);
        w_guard  = w_g[0];
        w_mask   = (48'd1 << (w_s6 - 6'd1)) - 48'd1;
        w_sticky = |(r2_p & w_mask);
    end

    // stage 4 pack logic
    logic [24:0] w_qr;
    logic [32:0] w_r;
    logic [31:0] w_res;

    always_comb begin
        w_qr = {1'b0, r3_q} + {24'd0, r3_inc};
        w_r  = ({21'd0, 12'(r3_e - 12'sd1)} << 23) + {8'd0, w_qr};
        if (r3_spec) begin
            w_res = r3_val;
        end else if (r3_zero) begin
            w_res = {r3_sg, 31'd0};
        end else if (r3_e <= 12'sd0) begin
            w_res = {r3_sg, 6'd0, w_qr};
        end else if (w_r >= 33'h0_7F80_0000) begin
            w_res = {r3_sg, 31'h7F80_0000};
        end else begin
            w_res = {r3_sg, w_r[30:0]};
        end
    end

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 4'd0;
        end else begin
            r_v <= {r_v[2:0], i_start};
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r1_sg   <= w_sg;
        r1_spec <= w_spec;
        r1_val  <= w_val;
        r1_xa   <= w_na.x;
        r1_fa   <= w_na.f;
        r1_xb   <= w_nb.x;
        r1_fb   <= w_nb.f;

        r2_sg   <= r1_sg;
        r2_spec <= r1_spec;
        r2_val  <= r1_val;
        r2_p    <= r1_fa * r1_fb;
        r2_e    <= 12'(r1_xa) + 12'(r1_xb) - 12'sd127;

        r3_sg   <= r2_sg;
        r3_spec <= r2_spec;
        r3_val  <= r2_val;
        r3_zero <= (w_s > 12'sd48);
        r3_q    <= w_q[23:0];
        r3_inc  <= w_guard && (w_sticky || w_q[0]);
        r3_e    <= w_e3;

        o_result <= w_res;
    end

    assign o_done = r_v[3];

endmodule

`default_nettype wire

FILE: src/codebook_group_dequantizer.sv
// top level of the codebook group dequantizer
// depends on cgd_pkg, cgd_if, cgd_ram and cgd_fmul
//
// usage:
// - i_in carries load items (op 0: write entry_value into codebook slot
//   entry_index) and weight bytes (op 1). Each group block starts with two
//   scale bytes (fp16, low byte first), then the packed codes, LSB first.
// - o_out carries one result per emitted code: scale times codebook entry,
//   its column, row and matrix end marks, the last-result-of-byte mark and
//   the bad scale flag.
// - i_cfg_we/i_cfg_addr/i_cfg_data write the four registers; write them only
//   while no byte is being worked on.
// - i_in.ready is high only while the sequencer is idle. Load items and
//   scale bytes leave the sequencer idle. A code byte is accepted, then each
//   code is unpacked and its result goes through the codebook read, the
//   multiplier and o_out before the next code; after the last code the byte
//   closes. The single shared multiplier serves every code in turn, so a new
//   byte is taken only once the last one is through.
// - a stalled receiver holds the result on o_out; nothing else moves meanwhile.
// - reset restores the register defaults and clears the stream position,
//   counters and scale; the codebook contents are undefined until loaded.
`default_nettype none

module codebook_group_dequantizer #(
    parameter int CODEBOOK_DEPTH = 256
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    cgd_in_if.sink                        i_in,
    cgd_out_if.source                     o_out,
    input  wire                           i_cfg_we,
    input  wire [1:0]                     i_cfg_addr,
    input  wire [cgd_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW    = $clog2(CODEBOOK_DEPTH);
    localparam int RECIP = 65536 / CODEBOOK_DEPTH;

    // fp16 to fp32 widening, subnormals normalized
    function automatic logic [31:0] widen_half(input logic [15:0] h);
        logic [4:0]  ex;
        logic [9:0]  man;
        logic [3:0]  sh;
        logic [10:0] m2;
        ex  = h[14:10];
        man = h[9:0];
        sh  = 4'd0;
        for (int i = 0; i < 10; i++) begin
            if (man[i]) begin
                sh = 4'(10 - i);
            end
        end
        m2 = {1'b0, man} << sh;
        if (ex == 5'd0) begin
            if (man == 10'd0) begin
                return {h[15], 31'd0};
            end
            return {h[15], 8'(8'd113 - {4'd0, sh}), m2[9:0], 13'd0};
        end
        if (ex == 5'h1F) begin
            return {h[15], 8'hFF, man, 13'd0};
        end
        return {h[15], 8'({3'd0, ex} + 8'd112), man, 13'd0};
    endfunction

    // configuration registers
    logic [3:0]  r_code_width;
    logic [12:0] r_group_length;
    logic [15:0] r_row_length, r_row_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_width   <= cgd_pkg::RST_CODE_WIDTH;
            r_group_length <= cgd_pkg::RST_GROUP_LENGTH;
            r_row_length   <= cgd_pkg::RST_ROW_LENGTH;
            r_row_count    <= cgd_pkg::RST_ROW_COUNT;
        end else if (i_cfg_we) begin
            case (cgd_pkg::t_cfg_idx'(i_cfg_addr))
                cgd_pkg::CFG_CODE_WIDTH:   r_code_width   <= i_cfg_data[3:0];
                cgd_pkg::CFG_GROUP_LENGTH: r_group_length <= i_cfg_data[12:0];
                cgd_pkg::CFG_ROW_LENGTH:   r_row_length   <= i_cfg_data;
                cgd_pkg::CFG_ROW_COUNT:    r_row_count    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // clamped register values and block size
    logic [3:0]  w_cw;
    logic [12:0] w_gl;
    logic [15:0] w_rl;
    logic [16:0] w_bits;
    logic [12:0] w_block_len;

    always_comb begin
        w_cw = r_code_width;
        if (r_code_width == 4'd0) begin
            w_cw = 4'd1;
        end else if (r_code_width > 4'd8) begin
            w_cw = 4'd8;
        end
        w_gl = r_group_length;
        if (r_group_length == 13'd0) begin
            w_gl = 13'd1;
        end else if (int'(r_group_length) > cgd_pkg::MAX_GROUP) begin
            w_gl = 13'(cgd_pkg::MAX_GROUP);
        end
        w_rl = (int'(r_row_length) > cgd_pkg::MAX_ROW) ? 16'(cgd_pkg::MAX_ROW) : r_row_length;
        w_bits      = {4'd0, w_gl} * {13'd0, w_cw};
        w_block_len = 13'(17'd2 + ((w_bits + 17'd7) >> 3));
    end

    // state
    cgd_pkg::t_state r_state, n_state;
    logic [12:0] r_pos, n_pos;
    logic [7:0]  r_scale_lo, n_scale_lo;
    logic [31:0] r_scale, n_scale;
    logic [14:0] r_buf, n_buf;
    logic [15:0] r_held, n_held;
    logic [12:0] r_cig, n_cig;
    logic [15:0] r_col, n_col;
    logic [15:0] r_row, n_row;
    logic [3:0]  r_n, n_n;
    logic        r_bad, n_bad;
    logic [15:0] r_o_col, n_o_col;
    logic        r_o_rend, n_o_rend, r_o_mend, n_o_mend, r_o_iend, n_o_iend;
    logic [31:0] r_o_weight, n_o_weight;

    logic        w_in_xfer, w_mul_start, w_mul_done;
    logic [31:0] w_mul_res, w_ram_rdata;
    logic        w_ram_we;

    // unpack step values
    logic        w_step, w_emit, w_more, w_rend, w_mend;
    logic [7:0]  w_code, w_cmask;
    logic [15:0] w_held_nx;
    logic [12:0] w_cig_nx, w_pos_nx;
    logic [22:0] w_wide;
    logic [24:0] w_qprod;
    logic [7:0]  w_qe;
    logic [16:0] w_qd;
    logic [8:0]  w_rem;
    logic [AW-1:0] w_raddr;

    assign w_in_xfer = i_in.valid && i_in.ready;

    // code extraction and codebook index wrap
    always_comb begin
        w_step    = (r_held >= {12'd0, w_cw}) && (r_cig < w_gl);
        w_cmask   = 8'((9'd1 << w_cw) - 9'd1);
        w_code    = r_buf[7:0] & w_cmask;
        w_held_nx = r_held - {12'd0, w_cw};
        w_cig_nx  = r_cig + 13'd1;
        w_emit    = (r_col < w_rl) && (r_n < 4'd8);
        w_more    = (w_held_nx >= {12'd0, w_cw}) && (w_cig_nx < w_gl)
                    && ({1'b0, r_col} + 17'd1 < {1'b0, w_rl}) && (r_n + 4'd1 < 4'd8);
        w_rend    = ({1'b0, r_col} + 17'd1 == {1'b0, w_rl});
        w_mend    = w_rend && ({1'b0, r_row} + 17'd1 >= {1'b0, r_row_count});
        w_pos_nx  = r_pos + 13'd1;
        w_wide    = {8'd0, r_buf} | ({15'd0, i_in.data.data_byte} << r_held[3:0]);
        w_qprod   = 25'({17'd0, w_code} * 25'(RECIP));
        w_qe      = w_qprod[23:16];
        w_qd      = 17'({9'd0, w_qe} * 17'(CODEBOOK_DEPTH));
        w_rem     = 9'({9'd0, w_code} - w_qd[8:0]);
        if (w_rem >= 9'(CODEBOOK_DEPTH)) begin
            w_rem = w_rem - 9'(CODEBOOK_DEPTH);
        end
        w_raddr   = w_rem[AW-1:0];
    end

    // next state and datapath updates
    always_comb begin
        n_state    = r_state;
        n_pos      = r_pos;
        n_scale_lo = r_scale_lo;
        n_scale    = r_scale;
        n_buf      = r_buf;
        n_held     = r_held;
        n_cig      = r_cig;
        n_col      = r_col;
        n_row      = r_row;
        n_n        = r_n;
        n_bad      = r_bad;
        n_o_col    = r_o_col;
        n_o_rend   = r_o_rend;
        n_o_mend   = r_o_mend;
        n_o_iend   = r_o_iend;
        n_o_weight = r_o_weight;
        w_mul_start = 1'b0;
        case (r_state)
            cgd_pkg::ST_IDLE: begin
                if (w_in_xfer && i_in.data.op == cgd_pkg::OP_BYTE) begin
                    if (r_pos == 13'd0) begin
                        n_scale_lo = i_in.data.data_byte;
                        n_pos      = 13'd1;
                    end else if (r_pos == 13'd1) begin
                        n_scale = widen_half({i_in.data.data_byte, r_scale_lo});
                        n_pos   = 13'd2;
                    end else begin
                        n_bad = (r_scale[30:23] == 8'hFF)
                                || (r_scale[31] && r_scale[30:0] != 31'd0);
                        n_buf  = (r_held < 16'd15) ? w_wide[14:0] : r_buf;
                        n_held = r_held + 16'd8;
                        n_n    = 4'd0;
                        n_state = cgd_pkg::ST_UNPACK;
                    end
                end
            end
            cgd_pkg::ST_UNPACK: begin
                if (w_step) begin
                    n_buf  = r_buf >> w_cw;
                    n_held = w_held_nx;
                    n_cig  = w_cig_nx;
                    if (w_emit) begin
                        n_o_col  = r_col;
                        n_o_rend = w_rend;
                        n_o_mend = w_mend;
                        n_o_iend = !w_more;
                        n_col    = r_col + 16'd1;
                        n_n      = r_n + 4'd1;
                        n_state  = cgd_pkg::ST_READ;
                    end
                end else begin
                    // byte done, close the block when it is complete
                    n_pos   = w_pos_nx;
                    n_state = cgd_pkg::ST_IDLE;
                    if (w_pos_nx >= w_block_len) begin
                        n_pos  = 13'd0;
                        n_buf  = 15'd0;
                        n_held = 16'd0;
                        n_cig  = 13'd0;
                        if (r_col >= w_rl) begin
                            n_col = 16'd0;
                            n_row = ({1'b0, r_row} + 17'd1 >= {1'b0, r_row_count}) ?
                                    16'd0 : r_row + 16'd1;
                        end
                    end
                end
            end
            cgd_pkg::ST_READ: begin
                w_mul_start = 1'b1;
                n_state     = cgd_pkg::ST_MUL;
            end
            cgd_pkg::ST_MUL: begin
                if (w_mul_done) begin
                    n_o_weight = w_mul_res;
                    n_state    = cgd_pkg::ST_OUT;
                end
            end
            cgd_pkg::ST_OUT: begin
                if (o_out.ready) begin
                    n_state = cgd_pkg::ST_UNPACK;
                end
            end
            default: n_state = cgd_pkg::ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= cgd_pkg::ST_IDLE;
            r_pos      <= 13'd0;
            r_scale_lo <= 8'd0;
            r_scale    <= 32'd0;
            r_buf      <= 15'd0;
            r_held     <= 16'd0;
            r_cig      <= 13'd0;
            r_col      <= 16'd0;
            r_row      <= 16'd0;
            r_n        <= 4'd0;
        end else begin
            r_state    <= n_state;
            r_pos      <= n_pos;
            r_scale_lo <= n_scale_lo;
            r_scale    <= n_scale;
            r_buf      <= n_buf;
            r_held     <= n_held;
            r_cig      <= n_cig;
            r_col      <= n_col;
            r_row      <= n_row;
            r_n        <= n_n;
        end
    end

    // result payload registers
    always_ff @(posedge i_clk) begin
        r_bad      <= n_bad;
        r_o_col    <= n_o_col;
        r_o_rend   <= n_o_rend;
        r_o_mend   <= n_o_mend;
        r_o_iend   <= n_o_iend;
        r_o_weight <= n_o_weight;
    end

    // codebook store
    assign w_ram_we = w_in_xfer && (i_in.data.op == cgd_pkg::OP_LOAD)
                      && ({1'b0, i_in.data.entry_index} < 9'(CODEBOOK_DEPTH));

    cgd_ram #(
        .WIDTH (32),
        .DEPTH (CODEBOOK_DEPTH)
    ) u_codebook (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (i_in.data.entry_index[AW-1:0]),
        .i_wdata (i_in.data.entry_value),
        .i_raddr (w_raddr),
        .o_rdata (w_ram_rdata)
    );

    // shared multiplier
    cgd_fmul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_mul_start),
        .i_a      (r_scale),
        .i_b      (w_ram_rdata),
        .o_done   (w_mul_done),
        .o_result (w_mul_res)
    );

    // channel outputs
    assign i_in.ready             = (r_state == cgd_pkg::ST_IDLE);
    assign o_out.valid            = (r_state == cgd_pkg::ST_OUT);
    assign o_out.data.weight_bits = r_o_weight;
    assign o_out.data.column      = r_o_col;
    assign o_out.data.row_end     = r_o_rend;
    assign o_out.data.matrix_end  = r_o_mend;
    assign o_out.data.item_end    = r_o_iend;
    assign o_out.data.scale_bad   = r_bad;

    // a pending result keeps the input closed
    a_out_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !i_in.ready)
        else $error("input open while a result is pending");

    // the multiplier only finishes while the sequencer waits for it
    a_mul_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_done |-> (r_state == cgd_pkg::ST_MUL))
        else $error("multiplier result outside its wait state");

    // matrix end is always also a row end
    a_matrix_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.matrix_end) |-> o_out.data.row_end)
        else $error("matrix end without row end");

    // a load transfer leaves the sequencer idle
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && i_in.data.op == cgd_pkg::OP_LOAD) |=> (r_state == cgd_pkg::ST_IDLE))
        else $error("load transfer started work");

endmodule

`default_nettype wire
